// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros used by the RGB to HSV top-level design file.
// The including scope must provide clk_i and rst_ni.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RTH_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rgb_to_hsv: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define RTH_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rgb_to_hsv: next-cycle check failed");

`endif

// ===== sv/rth_pkg.sv =====
// ----------------------------------------------------------------------------
// rth_pkg
// Shared constants and types of the RGB to HSV converter.
// ----------------------------------------------------------------------------
package rth_pkg;

  // Default channel width in bits.
  localparam int unsigned CHANNEL_BITS_DEF = 16;

  // Control flags that travel with each pixel down the pipeline.
  typedef struct packed {
    logic valid;  // Stage holds a pixel.
    logic gray;   // Max equals min, hue is forced to zero.
    logic black;  // Max is zero, saturation is forced to zero.
  } rth_ctrl_t;

endpackage

// ===== sv/rth_if.sv =====
// ----------------------------------------------------------------------------
// rth_if
// Valid/ready channel interfaces for RGB pixels in and HSV pixels out.
// ----------------------------------------------------------------------------

// RGB pixel channel.
interface rth_pix_if #(
  parameter int unsigned CHANNEL_BITS = rth_pkg::CHANNEL_BITS_DEF
);
  logic                    valid;
  logic                    ready;
  logic [CHANNEL_BITS-1:0] red_in;
  logic [CHANNEL_BITS-1:0] green_in;
  logic [CHANNEL_BITS-1:0] blue_in;

  modport source (output valid, output red_in, output green_in, output blue_in,
                  input ready);
  modport sink   (input valid, input red_in, input green_in, input blue_in,
                  output ready);
endinterface

// HSV pixel channel.
interface rth_hsv_if #(
  parameter int unsigned CHANNEL_BITS = rth_pkg::CHANNEL_BITS_DEF
);
  logic                    valid;
  logic                    ready;
  logic [CHANNEL_BITS-1:0] hue_out;
  logic [CHANNEL_BITS-1:0] sat_out;
  logic [CHANNEL_BITS-1:0] val_out;

  modport source (output valid, output hue_out, output sat_out, output val_out,
                  input ready);
  modport sink   (input valid, input hue_out, input sat_out, input val_out,
                  output ready);
endinterface

// ===== sv/rth_front.sv =====
// ----------------------------------------------------------------------------
// rth_front
// Two pipeline stages: max/min search, then the hue numerator and the
// starting remainders and divisors of the two long divisions.
// ----------------------------------------------------------------------------
module rth_front #(
  parameter int unsigned CHANNEL_BITS = rth_pkg::CHANNEL_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic [CHANNEL_BITS-1:0] red_i,
  input  logic [CHANNEL_BITS-1:0] green_i,
  input  logic [CHANNEL_BITS-1:0] blue_i,
  output rth_pkg::rth_ctrl_t      ctrl_o,
  output logic [CHANNEL_BITS+2:0] hrem_o,
  output logic [CHANNEL_BITS+2:0] hden_o,
  output logic [CHANNEL_BITS-1:0] srem_o,
  output logic [CHANNEL_BITS-1:0] sq_o,
  output logic [CHANNEL_BITS-1:0] mx_o
);

  localparam int unsigned W = CHANNEL_BITS;

  // Channel that holds the maximum, with red first, then green, then blue.
  typedef enum logic [1:0] {
    CH_RED   = 2'd0,
    CH_GREEN = 2'd1,
    CH_BLUE  = 2'd2
  } ch_e;

  logic            s1_vld_q;
  logic [W-1:0]    s1_mx_q, s1_mx_d;
  logic [W-1:0]    s1_mn_q, s1_mn_d;
  ch_e             s1_ch_q, s1_ch_d;
  logic [W:0]      s1_diff_q, s1_diff_d;

  logic [W-1:0]    df;
  logic [W+2:0]    df6;
  logic [W+3:0]    kdf;
  logic [W+3:0]    base;
  logic [W+3:0]    nsum;

  rth_pkg::rth_ctrl_t ctrl_q, ctrl_d;
  logic [W+2:0]    hrem_q, hrem_d;
  logic [W+2:0]    hden_q;
  logic [W-1:0]    srem_q, srem_d;
  logic [W-1:0]    sq_q, sq_d;
  logic [W-1:0]    mx_q;

  // Stage one: find max, min, the winning channel and its channel difference.
  always_comb begin
    if ((red_i >= green_i) && (red_i >= blue_i)) begin
      s1_ch_d   = CH_RED;
      s1_mx_d   = red_i;
      s1_diff_d = {1'b0, green_i} - {1'b0, blue_i};
    end else if (green_i >= blue_i) begin
      s1_ch_d   = CH_GREEN;
      s1_mx_d   = green_i;
      s1_diff_d = {1'b0, blue_i} - {1'b0, red_i};
    end else begin
      s1_ch_d   = CH_BLUE;
      s1_mx_d   = blue_i;
      s1_diff_d = {1'b0, red_i} - {1'b0, green_i};
    end
    s1_mn_d = red_i;
    if (green_i < s1_mn_d) begin
      s1_mn_d = green_i;
    end
    if (blue_i < s1_mn_d) begin
      s1_mn_d = blue_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (en_i) begin
      s1_vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_mx_q   <= s1_mx_d;
      s1_mn_q   <= s1_mn_d;
      s1_ch_q   <= s1_ch_d;
      s1_diff_q <= s1_diff_d;
    end
  end

  // Stage two: hue numerator folded into [0, 6*df), and the division seeds.
  // A negative numerator on the red sector gains one full turn (6*df).
  always_comb begin
    df  = s1_mx_q - s1_mn_q;
    df6 = ({3'b000, df} << 2) + ({3'b000, df} << 1);
    case (s1_ch_q)
      CH_RED:   kdf = '0;
      CH_GREEN: kdf = {3'b000, df, 1'b0};
      CH_BLUE:  kdf = {2'b00, df, 2'b00};
      default:  kdf = '0;
    endcase
    base = {{3{s1_diff_q[W]}}, s1_diff_q} + kdf;
    nsum = base[W+3] ? (base + {1'b0, df6}) : base;
    hrem_d = nsum[W+2:0];

    // Saturation numerator df*(2^W-1) splits into (df-1) high and -df low.
    srem_d = (df == '0) ? '0 : (df - W'(1));
    sq_d   = W'(0) - df;

    ctrl_d.valid = s1_vld_q;
    ctrl_d.gray  = (df == '0);
    ctrl_d.black = (s1_mx_q == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (en_i) begin
      ctrl_q <= ctrl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hrem_q <= hrem_d;
      hden_q <= df6;
      srem_q <= srem_d;
      sq_q   <= sq_d;
      mx_q   <= s1_mx_q;
    end
  end

  assign ctrl_o = ctrl_q;
  assign hrem_o = hrem_q;
  assign hden_o = hden_q;
  assign srem_o = srem_q;
  assign sq_o   = sq_q;
  assign mx_o   = mx_q;

endmodule

// ===== sv/rth_div_step.sv =====
// ----------------------------------------------------------------------------
// rth_div_step
// One registered restoring-division step for both the hue and the
// saturation quotient: each instance retires one quotient bit of each.
// ----------------------------------------------------------------------------
module rth_div_step #(
  parameter int unsigned CHANNEL_BITS = rth_pkg::CHANNEL_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  rth_pkg::rth_ctrl_t      ctrl_i,
  input  logic [CHANNEL_BITS+2:0] hrem_i,
  input  logic [CHANNEL_BITS+2:0] hden_i,
  input  logic [CHANNEL_BITS-1:0] hq_i,
  input  logic [CHANNEL_BITS-1:0] srem_i,
  input  logic [CHANNEL_BITS-1:0] sq_i,
  input  logic [CHANNEL_BITS-1:0] mx_i,
  output rth_pkg::rth_ctrl_t      ctrl_o,
  output logic [CHANNEL_BITS+2:0] hrem_o,
  output logic [CHANNEL_BITS+2:0] hden_o,
  output logic [CHANNEL_BITS-1:0] hq_o,
  output logic [CHANNEL_BITS-1:0] srem_o,
  output logic [CHANNEL_BITS-1:0] sq_o,
  output logic [CHANNEL_BITS-1:0] mx_o
);

  localparam int unsigned W = CHANNEL_BITS;

  logic [W+3:0] htry, hsub;
  logic         hge;
  logic [W:0]   stry, ssub;
  logic         sge;

  rth_pkg::rth_ctrl_t ctrl_q;
  logic [W+2:0] hrem_q, hrem_d;
  logic [W+2:0] hden_q;
  logic [W-1:0] hq_q, hq_d;
  logic [W-1:0] srem_q, srem_d;
  logic [W-1:0] sq_q, sq_d;
  logic [W-1:0] mx_q;

  // Hue: the numerator's low bits are zero, so a zero is shifted in.
  always_comb begin
    htry   = {hrem_i, 1'b0};
    hsub   = htry - {1'b0, hden_i};
    hge    = (htry >= {1'b0, hden_i});
    hrem_d = hge ? hsub[W+2:0] : htry[W+2:0];
    hq_d   = {hq_i[W-2:0], hge};
  end

  // Saturation: the low numerator bits leave the top of sq as quotient
  // bits enter at the bottom.
  always_comb begin
    stry   = {srem_i, sq_i[W-1]};
    ssub   = stry - {1'b0, mx_i};
    sge    = (stry >= {1'b0, mx_i});
    srem_d = sge ? ssub[W-1:0] : stry[W-1:0];
    sq_d   = {sq_i[W-2:0], sge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (en_i) begin
      ctrl_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hrem_q <= hrem_d;
      hden_q <= hden_i;
      hq_q   <= hq_d;
      srem_q <= srem_d;
      sq_q   <= sq_d;
      mx_q   <= mx_i;
    end
  end

  assign ctrl_o = ctrl_q;
  assign hrem_o = hrem_q;
  assign hden_o = hden_q;
  assign hq_o   = hq_q;
  assign srem_o = srem_q;
  assign sq_o   = sq_q;
  assign mx_o   = mx_q;

endmodule

// ===== sv/rgb_to_hsv.sv =====
// An accepted transaction passes the front-end stages, then the division stages.
// Throughput: one pixel per cycle unless the output stalls; the CHANNEL_BITS
// division stages retire one quotient bit each, so a new pixel enters every cycle.
// A stalled output freezes the whole pipeline and holds the input off.
// Reset (rst_ni low, asynchronous) clears all stage valid bits.
// ----------------------------------------------------------------------------
// rgb_to_hsv
// Fixed-point RGB to HSV pixel converter: max/min front end followed by
// pipelined restoring dividers for hue and saturation.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rgb_to_hsv #(
  parameter int unsigned CHANNEL_BITS = rth_pkg::CHANNEL_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rth_pix_if.sink    pix_i,
  rth_hsv_if.source  hsv_o
);

  localparam int unsigned W = CHANNEL_BITS;

  logic adv;

  rth_pkg::rth_ctrl_t ctrl [W+1];
  logic [W+2:0]       hrem [W+1];
  logic [W+2:0]       hden [W+1];
  logic [W-1:0]       hq   [W+1];
  logic [W-1:0]       srem [W+1];
  logic [W-1:0]       sq   [W+1];
  logic [W-1:0]       mx   [W+1];

  // The pipeline moves when its last stage is empty or being drained.
  assign adv         = !ctrl[W].valid || hsv_o.ready;
  assign pix_i.ready = adv;

  // Front end: max/min and division seeds.
  rth_front #(
    .CHANNEL_BITS(W)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .valid_i(pix_i.valid),
    .red_i  (pix_i.red_in),
    .green_i(pix_i.green_in),
    .blue_i (pix_i.blue_in),
    .ctrl_o (ctrl[0]),
    .hrem_o (hrem[0]),
    .hden_o (hden[0]),
    .srem_o (srem[0]),
    .sq_o   (sq[0]),
    .mx_o   (mx[0])
  );

  assign hq[0] = '0;

  // One division step per quotient bit.
  for (genvar i = 0; i < W; i++) begin : g_div
    rth_div_step #(
      .CHANNEL_BITS(W)
    ) u_step (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (adv),
      .ctrl_i(ctrl[i]),
      .hrem_i(hrem[i]),
      .hden_i(hden[i]),
      .hq_i  (hq[i]),
      .srem_i(srem[i]),
      .sq_i  (sq[i]),
      .mx_i  (mx[i]),
      .ctrl_o(ctrl[i+1]),
      .hrem_o(hrem[i+1]),
      .hden_o(hden[i+1]),
      .hq_o  (hq[i+1]),
      .srem_o(srem[i+1]),
      .sq_o  (sq[i+1]),
      .mx_o  (mx[i+1])
    );
  end

  // Output transaction, with the gray and black special cases applied.
  assign hsv_o.valid   = ctrl[W].valid;
  assign hsv_o.hue_out = ctrl[W].gray  ? '0 : hq[W];
  assign hsv_o.sat_out = ctrl[W].black ? '0 : sq[W];
  assign hsv_o.val_out = mx[W];

  // A finished hue division leaves a remainder below its divisor.
  `RTH_ASSERT_IMP(a_hue_rem, ctrl[W].valid && !ctrl[W].gray, hrem[W] < hden[W])
  // A finished saturation division leaves a remainder below the maximum.
  `RTH_ASSERT_IMP(a_sat_rem, ctrl[W].valid && !ctrl[W].black, srem[W] < mx[W])
  // A black pixel has zero saturation and zero hue.
  `RTH_ASSERT_IMP(a_black_zero, hsv_o.valid && (hsv_o.val_out == '0),
                  (hsv_o.sat_out == '0) && (hsv_o.hue_out == '0))

endmodule

// ===== verif/rgb_to_hsv_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rgb_to_hsv_checker
// Watches the pixel and HSV channels of the converter. Every accepted RGB
// transaction is converted here to the HSV values it must produce, and every
// accepted HSV transaction is compared field by field with the oldest one.
// ----------------------------------------------------------------------------
module rgb_to_hsv_checker #(
  parameter int unsigned CHANNEL_BITS = rth_pkg::CHANNEL_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    pix_valid_i,
  input  logic                    pix_ready_i,
  input  logic [CHANNEL_BITS-1:0] red_i,
  input  logic [CHANNEL_BITS-1:0] green_i,
  input  logic [CHANNEL_BITS-1:0] blue_i,
  input  logic                    hsv_valid_i,
  input  logic                    hsv_ready_i,
  input  logic [CHANNEL_BITS-1:0] hue_i,
  input  logic [CHANNEL_BITS-1:0] sat_i,
  input  logic [CHANNEL_BITS-1:0] val_i,
  output int                      fail_cnt_o,
  output int                      pending_cnt_o
);

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] hue;
    logic [CHANNEL_BITS-1:0] sat;
    logic [CHANNEL_BITS-1:0] val;
  } hsv_pixel_t;

  hsv_pixel_t hsv_expected_q[$];
  hsv_pixel_t want;
  hsv_pixel_t got;
  int         mismatches = 0;
  int         results_seen = 0;

  // Fixed-point RGB to HSV conversion. Hue rounds toward minus infinity,
  // which matters when the red channel is the maximum and blue exceeds green.
  function automatic hsv_pixel_t convert_pixel(input logic [CHANNEL_BITS-1:0] r,
                                               input logic [CHANNEL_BITS-1:0] g,
                                               input logic [CHANNEL_BITS-1:0] b);
    longint     red, grn, blu;
    longint     top, bot, span;
    longint     diff, sector, num, den, quot;
    hsv_pixel_t px;
    red  = longint'(r);
    grn  = longint'(g);
    blu  = longint'(b);
    top  = red;
    bot  = red;
    if (grn > top) top = grn;
    if (blu > top) top = blu;
    if (grn < bot) bot = grn;
    if (blu < bot) bot = blu;
    span = top - bot;

    // A gray pixel has no hue; ties for the maximum go to red, then green.
    px.hue = '0;
    if (span != 0) begin
      if (top == red) begin
        diff   = grn - blu;
        sector = 0;
      end else if (top == grn) begin
        diff   = blu - red;
        sector = 1;
      end else begin
        diff   = red - grn;
        sector = 2;
      end
      num  = (diff + 2 * sector * span) * (longint'(1) <<< CHANNEL_BITS);
      den  = 6 * span;
      quot = num / den;
      if ((num % den) != 0 && num < 0) quot = quot - 1;
      px.hue = quot[CHANNEL_BITS-1:0];
    end

    // A black pixel has no saturation.
    if (top == 0) px.sat = '0;
    else px.sat = CHANNEL_BITS'((span * ((longint'(1) <<< CHANNEL_BITS) - 1)) / top);
    px.val = top[CHANNEL_BITS-1:0];
    return px;
  endfunction

  // Count a failure; only the first few are printed in full.
  task automatic note_failure(input string what, input hsv_pixel_t exp_px,
                              input hsv_pixel_t act_px);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t ns: result %0d %s: expected h=%h s=%h v=%h, got h=%h s=%h v=%h",
               $time, results_seen, what, exp_px.hue, exp_px.sat, exp_px.val,
               act_px.hue, act_px.sat, act_px.val);
  endtask

  // Both channels are sampled at the same edge at which the block sees them.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pix_valid_i && pix_ready_i)
        hsv_expected_q.push_back(convert_pixel(red_i, green_i, blue_i));
      if (hsv_valid_i && hsv_ready_i) begin
        got = '{hue: hue_i, sat: sat_i, val: val_i};
        if (hsv_expected_q.size() == 0) begin
          note_failure("arrived with nothing expected", '0, got);
        end else begin
          want = hsv_expected_q.pop_front();
          if (want.hue !== got.hue) note_failure("has a wrong hue", want, got);
          else if (want.sat !== got.sat) note_failure("has a wrong saturation", want, got);
          else if (want.val !== got.val) note_failure("has a wrong value", want, got);
        end
        results_seen++;
      end
    end
    pending_cnt_o <= hsv_expected_q.size();
    fail_cnt_o    <= mismatches;
  end

endmodule

// ===== verif/tb_rgb_to_hsv.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rgb_to_hsv
// Drives RGB pixels into the converter, first a directed set of corner
// pixels, then random pixels in bursts with random gaps, while the HSV side
// stalls on a changing pattern. A checker beside the block predicts and
// compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_rgb_to_hsv;

  localparam int unsigned CW       = rth_pkg::CHANNEL_BITS_DEF;
  localparam int          CHAN_MAX = (1 << CW) - 1;
  localparam int          N_RANDOM = 1700;
  localparam int          DRAIN_LIMIT = 20000;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_cnt;
  int   pending_cnt;
  int   sent;
  int   burst_left;

  rth_pix_if #(.CHANNEL_BITS(CW)) pix_if ();
  rth_hsv_if #(.CHANNEL_BITS(CW)) hsv_if ();

  rgb_to_hsv #(
    .CHANNEL_BITS(CW)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .pix_i (pix_if),
    .hsv_o (hsv_if)
  );

  rgb_to_hsv_checker #(
    .CHANNEL_BITS(CW)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pix_valid_i  (pix_if.valid),
    .pix_ready_i  (pix_if.ready),
    .red_i        (pix_if.red_in),
    .green_i      (pix_if.green_in),
    .blue_i       (pix_if.blue_in),
    .hsv_valid_i  (hsv_if.valid),
    .hsv_ready_i  (hsv_if.ready),
    .hue_i        (hsv_if.hue_out),
    .sat_i        (hsv_if.sat_out),
    .val_i        (hsv_if.val_out),
    .fail_cnt_o   (fail_cnt),
    .pending_cnt_o(pending_cnt)
  );

  always #5 clk_i = ~clk_i;

  // Hard stop in case the pipeline hangs.
  initial begin
    #10ms;
    $display("rgb_to_hsv test failed");
    $finish;
  end

  // Receiver: picks a stall pattern at random, keeps it for a randomly drawn span, then picks anew.
  initial begin : receiver
    int mode;
    int left;
    int hold;
    mode = 0;
    left = 0;
    hold = 0;
    hsv_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(50, 300);
      end
      left--;
      case (mode)
        0: hsv_if.ready <= 1'b1;
        1: hsv_if.ready <= ($urandom_range(0, 3) != 0);
        2: hsv_if.ready <= ($urandom_range(0, 3) == 0);
        default: begin
          // Long stalls followed by short open windows.
          if (hold == 0) hold = $urandom_range(1, 20);
          hold--;
          hsv_if.ready <= (hold < 3);
        end
      endcase
    end
  end

  // Present one pixel and hold it until the block takes it.
  task automatic send_pixel(input logic [CW-1:0] r, input logic [CW-1:0] g,
                            input logic [CW-1:0] b);
    pix_if.valid    <= 1'b1;
    pix_if.red_in   <= r;
    pix_if.green_in <= g;
    pix_if.blue_in  <= b;
    do @(posedge clk_i); while (!pix_if.ready);
    sent++;
  endtask

  // Lower valid for a number of cycles; zero keeps the stream going.
  task automatic idle_sender(input int cycles);
    if (cycles > 0) begin
      pix_if.valid <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // Hold the input off until every result in flight has come back.
  task automatic wait_results_drained();
    int guard;
    guard = 0;
    idle_sender(1);
    while (pending_cnt != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk_i);
      guard++;
    end
  endtask

  function automatic logic [CW-1:0] clamp_channel(input int v);
    if (v < 0) return '0;
    if (v > CHAN_MAX) return CW'(CHAN_MAX);
    return CW'(v);
  endfunction

  function automatic logic [CW-1:0] edge_channel();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return CW'(1);
      2: return CW'(CHAN_MAX);
      3: return CW'(CHAN_MAX - 1);
      default: return CW'($urandom_range(0, CHAN_MAX));
    endcase
  endfunction

  // Random pixel drawn from a mix of uniform, near-gray, tied, extreme and
  // very dark pixels.
  task automatic random_pixel(output logic [CW-1:0] r, output logic [CW-1:0] g,
                              output logic [CW-1:0] b);
    int base;
    base = $urandom_range(0, CHAN_MAX);
    case ($urandom_range(0, 5))
      0, 1: begin
        r = CW'($urandom_range(0, CHAN_MAX));
        g = CW'($urandom_range(0, CHAN_MAX));
        b = CW'($urandom_range(0, CHAN_MAX));
      end
      2: begin
        r = clamp_channel(base + $urandom_range(0, 6) - 3);
        g = clamp_channel(base + $urandom_range(0, 6) - 3);
        b = clamp_channel(base + $urandom_range(0, 6) - 3);
      end
      3: begin
        r = CW'(base);
        g = CW'(base);
        b = CW'($urandom_range(0, CHAN_MAX));
        case ($urandom_range(0, 2))
          0: ;
          1: begin r = b; b = CW'(base); end
          default: begin g = b; b = CW'(base); end
        endcase
      end
      4: begin
        r = edge_channel();
        g = edge_channel();
        b = edge_channel();
      end
      default: begin
        r = CW'($urandom_range(0, 15));
        g = CW'($urandom_range(0, 15));
        b = CW'($urandom_range(0, 15));
      end
    endcase
  endtask

  // Stimulus and verdict.
  initial begin : stimulus
    logic [CW-1:0] r, g, b;
    int            guard;
    sent       = 0;
    burst_left = 0;
    pix_if.valid    <= 1'b0;
    pix_if.red_in   <= '0;
    pix_if.green_in <= '0;
    pix_if.blue_in  <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed corners: black, white, primaries, ties for the maximum,
    // hue wrap below zero, single-code steps and near-gray pixels.
    send_pixel('0, '0, '0);
    send_pixel(CW'(CHAN_MAX), CW'(CHAN_MAX), CW'(CHAN_MAX));
    send_pixel(CW'(CHAN_MAX), '0, '0);
    send_pixel('0, CW'(CHAN_MAX), '0);
    send_pixel('0, '0, CW'(CHAN_MAX));
    send_pixel(CW'(CHAN_MAX), CW'(CHAN_MAX), '0);
    send_pixel('0, CW'(CHAN_MAX), CW'(CHAN_MAX));
    send_pixel(CW'(CHAN_MAX), '0, CW'(CHAN_MAX));
    send_pixel(CW'(CHAN_MAX), '0, CW'(1));
    send_pixel(CW'(CHAN_MAX), CW'(1), '0);
    send_pixel(CW'(1), '0, '0);
    send_pixel('0, CW'(1), '0);
    send_pixel('0, '0, CW'(1));
    send_pixel(CW'(1000), CW'(2000), CW'(3000));
    send_pixel(CW'(3000), CW'(1000), CW'(2000));
    send_pixel(CW'(2000), CW'(3000), CW'(1000));
    send_pixel(CW'(CHAN_MAX), CW'(CHAN_MAX - 1), '0);
    send_pixel('0, CW'(CHAN_MAX), CW'(CHAN_MAX - 1));
    send_pixel(CW'(CHAN_MAX - 1), '0, CW'(CHAN_MAX));
    send_pixel(CW'(12345), CW'(12345), CW'(12346));
    send_pixel(CW'(1), CW'(1), '0);
    send_pixel(CW'(1 << (CW - 1)), CW'((1 << (CW - 1)) - 1), CW'(1 << (CW - 1)));
    wait_results_drained();

    // Random pixels in bursts; halfway through the input is held off
    // until the pipeline is empty.
    for (int i = 0; i < N_RANDOM; i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        if ($urandom_range(0, 3) == 0) idle_sender(0);
        else idle_sender($urandom_range(1, 8));
      end
      if (i == N_RANDOM / 2) wait_results_drained();
      random_pixel(r, g, b);
      send_pixel(r, g, b);
      burst_left--;
    end
    pix_if.valid <= 1'b0;

    // Wait for the last results, then a little longer for strays.
    guard = 0;
    while (pending_cnt != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (CW + 20) @(posedge clk_i);

    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("rgb_to_hsv test passed");
    end else begin
      $display("rgb_to_hsv test failed");
    end
    $finish;
  end

endmodule
